@@ rtl/sct_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and character helpers for the shell command tokenizer.
// No dependencies; the top level refers to everything here by scoped name.
package sct_pkg;

   // Result event codes
   localparam logic [1:0] EV_TEXT = 2'd0;
   localparam logic [1:0] EV_END  = 2'd1;
   localparam logic [1:0] EV_LINE = 2'd2;
   localparam logic [1:0] EV_ERR  = 2'd3;

   // Token kinds reported on a token end
   localparam logic [3:0] KIND_NONE   = 4'd0;
   localparam logic [3:0] KIND_WORD   = 4'd0;
   localparam logic [3:0] KIND_VAR    = 4'd1;
   localparam logic [3:0] KIND_LT     = 4'd2;
   localparam logic [3:0] KIND_GT     = 4'd3;
   localparam logic [3:0] KIND_APPEND = 4'd4;
   localparam logic [3:0] KIND_PIPE   = 4'd5;
   localparam logic [3:0] KIND_AMP    = 4'd6;
   localparam logic [3:0] KIND_SEMI   = 4'd7;
   localparam logic [3:0] KIND_LPAREN = 4'd8;
   localparam logic [3:0] KIND_RPAREN = 4'd9;

   // Characters with a meaning to the lexer
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_PIPE   = 8'h7C;
   localparam logic [7:0] CH_AMP    = 8'h26;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;

   // Number of result slots one byte can fill
   localparam int unsigned MAX_RESULTS = 3;

   // Lexer mode, one-hot
   typedef enum logic [6:0] {
      MODE_IDLE   = 7'b0000001,
      MODE_WORD   = 7'b0000010,
      MODE_QUOTE  = 7'b0000100,
      MODE_SKIP   = 7'b0001000,
      MODE_DOLLAR = 7'b0010000,
      MODE_VAR    = 7'b0100000,
      MODE_GT     = 7'b1000000
   } mode_type;

   // One result item
   typedef struct packed {
      logic [1:0] event_res;
      logic [3:0] kind;
      logic [7:0] text_byte;
      logic       last;
   } item_type;

   // Outcome of lexing a byte from the idle mode
   typedef struct packed {
      mode_type mode;
      logic     emit;
      item_type item;
   } idle_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
   endfunction

   // Kind of a symbol character, KIND_NONE when not a symbol
   function automatic logic [3:0] symbol_kind(input logic [7:0] c);
      logic [3:0] k;
      k = KIND_NONE;
      unique case (c)
         CH_LT:     k = KIND_LT;
         CH_GT:     k = KIND_GT;
         CH_PIPE:   k = KIND_PIPE;
         CH_AMP:    k = KIND_AMP;
         CH_SEMI:   k = KIND_SEMI;
         CH_LPAREN: k = KIND_LPAREN;
         CH_RPAREN: k = KIND_RPAREN;
         default:   k = KIND_NONE;
      endcase
      return k;
   endfunction

   function automatic item_type make_item(input logic [1:0] ev, input logic [3:0] kind,
                                          input logic [7:0] b);
      item_type it;
      it.event_res = ev;
      it.kind      = kind;
      it.text_byte = b;
      it.last      = 1'b0;
      return it;
   endfunction

   // Start of a token: what a byte does when no token is open
   function automatic idle_type idle_step(input logic [7:0] c);
      idle_type r;
      logic [3:0] k;
      k      = symbol_kind(c);
      r.mode = MODE_IDLE;
      r.emit = 1'b0;
      r.item = make_item(EV_TEXT, KIND_NONE, CH_NUL);
      priority if (is_space(c)) begin
         r.mode = MODE_IDLE;
      end else if (c == CH_NUL) begin
         r.emit = 1'b1;
         r.item = make_item(EV_LINE, KIND_NONE, CH_NUL);
      end else if (c == CH_QUOTE) begin
         r.mode = MODE_QUOTE;
      end else if (c == CH_DOLLAR) begin
         r.mode = MODE_DOLLAR;
      end else if (c == CH_GT) begin
         r.mode = MODE_GT;
      end else if (k != KIND_NONE) begin
         r.emit = 1'b1;
         r.item = make_item(EV_END, k, CH_NUL);
      end else begin
         r.mode = MODE_WORD;
         r.emit = 1'b1;
         r.item = make_item(EV_TEXT, KIND_NONE, c);
      end
      return r;
   endfunction

endpackage

@@ rtl/shell_command_tokenizer_unit.sv @@
`timescale 1ns / 1ps
// Shell command line tokenizer: byte-in lexer with a three-slot result buffer.
// Depends on sct_pkg for codes, types and character helpers.

// Takes one command line byte per transfer on req_ (byte 0 ends the line) and
// delivers token text bytes, token ends with their kind, line ends and an
// unmatched-quote error on rsp_, with rsp_last marking the final result of each
// byte. A byte is lexed in the cycle it is accepted and its zero to three
// results go into a register buffer; the result port then moves one result per
// cycle while rsp_ready is high. A byte that gives at most one result therefore
// sustains one byte per cycle while rsp_ready is high; a byte that gives more
// results holds the input off while the single result port drains the buffer to
// one. A new byte is taken while the last buffered result is being taken.
module shell_command_tokenizer_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_ch,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_event_res,
   output logic [3:0] rsp_kind,
   output logic [7:0] rsp_text_byte,
   output logic       rsp_last
);

   sct_pkg::mode_type mode_ff, mode_in;
   sct_pkg::item_type slot_ff [0:sct_pkg::MAX_RESULTS-1];
   sct_pkg::item_type slot_in [0:sct_pkg::MAX_RESULTS-1];
   logic [1:0]        cnt_ff, cnt_in;

   sct_pkg::item_type lex_item [0:sct_pkg::MAX_RESULTS-1];
   logic [1:0]        lex_cnt;
   sct_pkg::mode_type lex_mode;
   sct_pkg::idle_type idl;
   logic              sep;
   logic              accept;
   logic              take;

   // Handshakes: take a byte once the buffer is empty or emptying now
   assign rsp_valid = (cnt_ff != 2'd0);
   assign take      = rsp_valid && rsp_ready;
   assign req_ready = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_ready);
   assign accept    = req_valid && req_ready;

   // Lex the incoming byte against the current mode
   always_comb begin
      for (int i = 0; i < sct_pkg::MAX_RESULTS; i++) begin
         lex_item[i] = sct_pkg::make_item(sct_pkg::EV_TEXT, sct_pkg::KIND_NONE,
                                          sct_pkg::CH_NUL);
      end
      lex_cnt  = 2'd0;
      lex_mode = mode_ff;
      idl      = sct_pkg::idle_step(req_ch);
      sep      = (req_ch == sct_pkg::CH_NUL) || sct_pkg::is_space(req_ch);

      unique case (mode_ff)
         sct_pkg::MODE_WORD: begin
            if (sep || (sct_pkg::symbol_kind(req_ch) != sct_pkg::KIND_NONE)) begin
               lex_item[lex_cnt] = sct_pkg::make_item(sct_pkg::EV_END,
                                                      sct_pkg::KIND_WORD, sct_pkg::CH_NUL);
               lex_cnt = lex_cnt + 2'd1;
               if (idl.emit) begin
                  lex_item[lex_cnt] = idl.item;
                  lex_cnt = lex_cnt + 2'd1;
               end
               lex_mode = idl.mode;
            end else begin
               lex_item[lex_cnt] = sct_pkg::make_item(sct_pkg::EV_TEXT,
                                                      sct_pkg::KIND_NONE, req_ch);
               lex_cnt = lex_cnt + 2'd1;
            end
         end
         sct_pkg::MODE_QUOTE: begin
            priority if (req_ch == sct_pkg::CH_QUOTE) begin
               lex_item[lex_cnt] = sct_pkg::make_item(sct_pkg::EV_END,
                                                      sct_pkg::KIND_WORD, sct_pkg::CH_NUL);
               lex_cnt  = lex_cnt + 2'd1;
               lex_mode = sct_pkg::MODE_SKIP;
            end else if (req_ch == sct_pkg::CH_NUL) begin
               lex_item[lex_cnt] = sct_pkg::make_item(sct_pkg::EV_ERR,
                                                      sct_pkg::KIND_NONE, sct_pkg::CH_NUL);
               lex_cnt  = lex_cnt + 2'd1;
               lex_mode = sct_pkg::MODE_IDLE;
            end else begin
               lex_item[lex_cnt] = sct_pkg::make_item(sct_pkg::EV_TEXT,
                                                      sct_pkg::KIND_NONE, req_ch);
               lex_cnt = lex_cnt + 2'd1;
            end
         end
         sct_pkg::MODE_SKIP: begin
            // Drop glued bytes after a closing quote
            if (sep || (sct_pkg::symbol_kind(req_ch) != sct_pkg::KIND_NONE)) begin
               if (idl.emit) begin
                  lex_item[lex_cnt] = idl.item;
                  lex_cnt = lex_cnt + 2'd1;
               end
               lex_mode = idl.mode;
            end
         end
         sct_pkg::MODE_DOLLAR: begin
            if (sep) begin
               // Lone dollar is the plain word "$"
               lex_item[lex_cnt] = sct_pkg::make_item(sct_pkg::EV_TEXT,
                                                      sct_pkg::KIND_NONE, sct_pkg::CH_DOLLAR);
               lex_cnt = lex_cnt + 2'd1;
               lex_item[lex_cnt] = sct_pkg::make_item(sct_pkg::EV_END,
                                                      sct_pkg::KIND_WORD, sct_pkg::CH_NUL);
               lex_cnt = lex_cnt + 2'd1;
               if (idl.emit) begin
                  lex_item[lex_cnt] = idl.item;
                  lex_cnt = lex_cnt + 2'd1;
               end
               lex_mode = idl.mode;
            end else begin
               lex_item[lex_cnt] = sct_pkg::make_item(sct_pkg::EV_TEXT,
                                                      sct_pkg::KIND_NONE, req_ch);
               lex_cnt  = lex_cnt + 2'd1;
               lex_mode = sct_pkg::MODE_VAR;
            end
         end
         sct_pkg::MODE_VAR: begin
            if (sep) begin
               lex_item[lex_cnt] = sct_pkg::make_item(sct_pkg::EV_END,
                                                      sct_pkg::KIND_VAR, sct_pkg::CH_NUL);
               lex_cnt = lex_cnt + 2'd1;
               if (idl.emit) begin
                  lex_item[lex_cnt] = idl.item;
                  lex_cnt = lex_cnt + 2'd1;
               end
               lex_mode = idl.mode;
            end else begin
               lex_item[lex_cnt] = sct_pkg::make_item(sct_pkg::EV_TEXT,
                                                      sct_pkg::KIND_NONE, req_ch);
               lex_cnt = lex_cnt + 2'd1;
            end
         end
         sct_pkg::MODE_GT: begin
            // Resolve a pending '>' as append or plain redirect
            if (req_ch == sct_pkg::CH_GT) begin
               lex_item[lex_cnt] = sct_pkg::make_item(sct_pkg::EV_END,
                                                      sct_pkg::KIND_APPEND, sct_pkg::CH_NUL);
               lex_cnt  = lex_cnt + 2'd1;
               lex_mode = sct_pkg::MODE_IDLE;
            end else begin
               lex_item[lex_cnt] = sct_pkg::make_item(sct_pkg::EV_END,
                                                      sct_pkg::KIND_GT, sct_pkg::CH_NUL);
               lex_cnt = lex_cnt + 2'd1;
               if (idl.emit) begin
                  lex_item[lex_cnt] = idl.item;
                  lex_cnt = lex_cnt + 2'd1;
               end
               lex_mode = idl.mode;
            end
         end
         default: begin
            if (idl.emit) begin
               lex_item[lex_cnt] = idl.item;
               lex_cnt = lex_cnt + 2'd1;
            end
            lex_mode = idl.mode;
         end
      endcase

      // Flag the final result of this byte
      if (lex_cnt != 2'd0) begin
         lex_item[lex_cnt - 2'd1].last = 1'b1;
      end
   end

   // Load the buffer on a byte transfer, shift it down on a result transfer
   always_comb begin
      mode_in = mode_ff;
      cnt_in  = cnt_ff;
      for (int i = 0; i < sct_pkg::MAX_RESULTS; i++) begin
         slot_in[i] = slot_ff[i];
      end
      if (accept) begin
         mode_in = lex_mode;
         cnt_in  = lex_cnt;
         for (int i = 0; i < sct_pkg::MAX_RESULTS; i++) begin
            slot_in[i] = lex_item[i];
         end
      end else if (take) begin
         cnt_in = cnt_ff - 2'd1;
         for (int i = 0; i < sct_pkg::MAX_RESULTS - 1; i++) begin
            slot_in[i] = slot_ff[i + 1];
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= sct_pkg::MODE_IDLE;
         cnt_ff  <= 2'd0;
      end else begin
         mode_ff <= mode_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Result slots
   always_ff @(posedge clock) begin
      for (int i = 0; i < sct_pkg::MAX_RESULTS; i++) begin
         slot_ff[i] <= slot_in[i];
      end
   end

   // Present the head slot
   assign rsp_event_res = slot_ff[0].event_res;
   assign rsp_kind      = slot_ff[0].kind;
   assign rsp_text_byte = slot_ff[0].text_byte;
   assign rsp_last      = slot_ff[0].last;

endmodule
